>>> src/x86ild_pkg.sv
// x86ild_pkg: shared types and constants for the x86-64 instruction length decoder
// no dependencies
`default_nettype none
package x86ild_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0] instr_length;
    logic [1:0] decode_status;
    logic       is_syscall;
  } out_item_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_PREFIX  = 2'd3;

  // immediate classes
  localparam logic [3:0] IM_NONE = 4'd0;
  localparam logic [3:0] IM_B    = 4'd1;
  localparam logic [3:0] IM_W    = 4'd2;
  localparam logic [3:0] IM_3    = 4'd3;
  localparam logic [3:0] IM_Z    = 4'd4;
  localparam logic [3:0] IM_V    = 4'd5;
  localparam logic [3:0] IM_M    = 4'd6;
  localparam logic [3:0] IM_TB   = 4'd7;
  localparam logic [3:0] IM_TZ   = 4'd8;
  localparam logic [3:0] IM_REL4 = 4'd9;

  // opcode class: unknown, has modrm, immediate class
  typedef struct packed {
    logic       unk;
    logic       mrm;
    logic [3:0] imm;
  } op_class_t;

  // front-end classification carried through the queue
  typedef struct packed {
    logic      region_end;
    logic      legacy_pfx;
    logic      rex;
    logic      is_66;
    logic      is_67;
    logic      is_0f;
    logic      is_05;
    logic      is_38;
    logic      is_3a;
    logic      is_c4;
    logic      is_c5;
    logic      is_62;
    logic      is_8f;
    op_class_t cls1;
    op_class_t cls0f;
    logic [7:0] code_byte;
  } cls_item_t;

  function automatic op_class_t mk(input logic u, input logic m, input logic [3:0] i);
    op_class_t c;
    c.unk = u;
    c.mrm = m;
    c.imm = i;
    return c;
  endfunction

  function automatic op_class_t one_byte_class(input logic [7:0] op);
    op_class_t c;
    c = mk(1'b1, 1'b0, IM_NONE);
    if (op < 8'h40) begin
      if (op[2:0] <= 3'd3) c = mk(1'b0, 1'b1, IM_NONE);
      else if (op[2:0] == 3'd4) c = mk(1'b0, 1'b0, IM_B);
      else if (op[2:0] == 3'd5) c = mk(1'b0, 1'b0, IM_Z);
    end else if (op < 8'h50) begin
      c = mk(1'b1, 1'b0, IM_NONE);
    end else if (op < 8'h60) begin
      c = mk(1'b0, 1'b0, IM_NONE);
    end else if (op >= 8'h70 && op <= 8'h7F) begin
      c = mk(1'b0, 1'b0, IM_B);
    end else if (op >= 8'h80 && op <= 8'h8F) begin
      if (op == 8'h80 || op == 8'h82 || op == 8'h83) c = mk(1'b0, 1'b1, IM_B);
      else if (op == 8'h81) c = mk(1'b0, 1'b1, IM_Z);
      else c = mk(1'b0, 1'b1, IM_NONE);
    end else if (op >= 8'h90 && op <= 8'h9F) begin
      c = mk(op == 8'h9A, 1'b0, IM_NONE);
    end else if (op >= 8'hA0 && op <= 8'hA3) begin
      c = mk(1'b0, 1'b0, IM_M);
    end else if (op == 8'hA8) begin
      c = mk(1'b0, 1'b0, IM_B);
    end else if (op == 8'hA9) begin
      c = mk(1'b0, 1'b0, IM_Z);
    end else if (op >= 8'hA4 && op <= 8'hAF) begin
      c = mk(1'b0, 1'b0, IM_NONE);
    end else if (op >= 8'hB0 && op <= 8'hB7) begin
      c = mk(1'b0, 1'b0, IM_B);
    end else if (op >= 8'hB8 && op <= 8'hBF) begin
      c = mk(1'b0, 1'b0, IM_V);
    end else if (op >= 8'hD8 && op <= 8'hDF) begin
      c = mk(1'b0, 1'b1, IM_NONE);
    end else begin
      case (op)
        8'h60, 8'h61, 8'h6C, 8'h6D, 8'h6E, 8'h6F: c = mk(1'b0, 1'b0, IM_NONE);
        8'h63: c = mk(1'b0, 1'b1, IM_NONE);
        8'h68: c = mk(1'b0, 1'b0, IM_Z);
        8'h69: c = mk(1'b0, 1'b1, IM_Z);
        8'h6A: c = mk(1'b0, 1'b0, IM_B);
        8'h6B: c = mk(1'b0, 1'b1, IM_B);
        8'hC0, 8'hC1, 8'hC6: c = mk(1'b0, 1'b1, IM_B);
        8'hC7: c = mk(1'b0, 1'b1, IM_Z);
        8'hC2, 8'hCA: c = mk(1'b0, 1'b0, IM_W);
        8'hC8: c = mk(1'b0, 1'b0, IM_3);
        8'hC3, 8'hC9, 8'hCB, 8'hCC, 8'hCE, 8'hCF: c = mk(1'b0, 1'b0, IM_NONE);
        8'hCD, 8'hD4, 8'hD5: c = mk(1'b0, 1'b0, IM_B);
        8'hD0, 8'hD1, 8'hD2, 8'hD3: c = mk(1'b0, 1'b1, IM_NONE);
        8'hD6, 8'hD7: c = mk(1'b0, 1'b0, IM_NONE);
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hEB:
          c = mk(1'b0, 1'b0, IM_B);
        8'hE8, 8'hE9: c = mk(1'b0, 1'b0, IM_Z);
        8'hEA, 8'hEC, 8'hED, 8'hEE, 8'hEF: c = mk(1'b0, 1'b0, IM_NONE);
        8'hF1, 8'hF4, 8'hF5: c = mk(1'b0, 1'b0, IM_NONE);
        8'hF6: c = mk(1'b0, 1'b1, IM_TB);
        8'hF7: c = mk(1'b0, 1'b1, IM_TZ);
        8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD: c = mk(1'b0, 1'b0, IM_NONE);
        8'hFE, 8'hFF: c = mk(1'b0, 1'b1, IM_NONE);
        default: c = mk(1'b1, 1'b0, IM_NONE);
      endcase
    end
    return c;
  endfunction

  // 0F map; jcc rel32 comes back as IM_Z, the vex path turns it into IM_REL4
  function automatic op_class_t map0f_class(input logic [7:0] op);
    op_class_t c;
    c = mk(1'b1, 1'b0, IM_NONE);
    if (op >= 8'h80 && op <= 8'h8F) begin
      c = mk(1'b0, 1'b0, IM_Z);
    end else if (op == 8'h0F || op == 8'hA4 || op == 8'hAC || op == 8'hBA ||
                 op == 8'hC2 || op == 8'hC4 || op == 8'hC5 || op == 8'hC6) begin
      c = mk(1'b0, 1'b1, IM_B);
    end else begin
      case (op)
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0E, 8'h30, 8'h31, 8'h32,
        8'h33, 8'h34, 8'h35, 8'h37, 8'h77, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9:
          c = mk(1'b0, 1'b0, IM_NONE);
        8'h0D, 8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAE, 8'hAF:
          c = mk(1'b0, 1'b1, IM_NONE);
        default: begin
          if (op >= 8'hC8 && op <= 8'hCF) c = mk(1'b0, 1'b0, IM_NONE);
          else if ((op >= 8'h10 && op <= 8'h23) || (op >= 8'h28 && op <= 8'h2F) ||
                   (op >= 8'h40 && op <= 8'h7F) || (op >= 8'h90 && op <= 8'h9F) ||
                   (op >= 8'hB0 && op <= 8'hC7) || op >= 8'hD0)
            c = mk(1'b0, 1'b1, IM_NONE);
        end
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/x86ild_front.sv
// x86ild_front: classifies each code byte against the opcode tables
// depends on x86ild_pkg
`default_nettype none
module x86ild_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire x86ild_pkg::in_item_t  in_data,
  output logic                       cls_valid,
  input  wire logic                  cls_ready,
  output x86ild_pkg::cls_item_t      cls_data
);
  logic                  valid_r;
  x86ild_pkg::cls_item_t data_r;
  x86ild_pkg::cls_item_t data_nxt;
  logic [7:0]            b;

  assign b = in_data.code_byte;
  assign in_ready = !valid_r || cls_ready;
  assign cls_valid = valid_r;
  assign cls_data = data_r;

  always_comb begin
    data_nxt.region_end = in_data.region_end;
    data_nxt.legacy_pfx = b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E ||
                          b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
                          b == 8'h65 || b == 8'h66 || b == 8'h67;
    data_nxt.rex   = b[7:4] == 4'h4;
    data_nxt.is_66 = b == 8'h66;
    data_nxt.is_67 = b == 8'h67;
    data_nxt.is_0f = b == 8'h0F;
    data_nxt.is_05 = b == 8'h05;
    data_nxt.is_38 = b == 8'h38;
    data_nxt.is_3a = b == 8'h3A;
    data_nxt.is_c4 = b == 8'hC4;
    data_nxt.is_c5 = b == 8'hC5;
    data_nxt.is_62 = b == 8'h62;
    data_nxt.is_8f = b == 8'h8F;
    data_nxt.cls1  = x86ild_pkg::one_byte_class(b);
    data_nxt.cls0f = x86ild_pkg::map0f_class(b);
    data_nxt.code_byte = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end
endmodule
`default_nettype wire

>>> src/x86ild_fifo.sv
// x86ild_fifo: two-entry queue between the classifier and the length tracker
// depends on x86ild_pkg
`default_nettype none
module x86ild_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_valid,
  output logic                        wr_ready,
  input  wire x86ild_pkg::cls_item_t  wr_data,
  output logic                        rd_valid,
  input  wire logic                   rd_ready,
  output x86ild_pkg::cls_item_t       rd_data
);
  x86ild_pkg::cls_item_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd_en) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !rd_valid)
    else $error("read from empty queue");
endmodule
`default_nettype wire

>>> src/x86ild_back.sv
// x86ild_back: per-byte length state machine with registered result output
// depends on x86ild_pkg
`default_nettype none
module x86ild_back #(
  parameter int MAX_PREFIX_BYTES = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cls_valid,
  output logic                        cls_ready,
  input  wire x86ild_pkg::cls_item_t  cls_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output x86ild_pkg::out_item_t       out_data
);
  localparam logic [3:0] PH_PREFIX   = 4'd0;
  localparam logic [3:0] PH_VEX3_MAP = 4'd1;
  localparam logic [3:0] PH_EVEX_MAP = 4'd2;
  localparam logic [3:0] PH_XOP_MAP  = 4'd3;
  localparam logic [3:0] PH_ESC_REST = 4'd4;
  localparam logic [3:0] PH_VOPCODE  = 4'd5;
  localparam logic [3:0] PH_OP0F     = 4'd6;
  localparam logic [3:0] PH_OP3      = 4'd7;
  localparam logic [3:0] PH_MODRM    = 4'd8;
  localparam logic [3:0] PH_SIB      = 4'd9;
  localparam logic [3:0] PH_DISP     = 4'd10;
  localparam logic [3:0] PH_IMM      = 4'd11;

  localparam logic [1:0] GO_ON  = 2'd0;
  localparam logic [1:0] GO_OK  = 2'd1;
  localparam logic [1:0] GO_UNK = 2'd2;
  localparam logic [1:0] GO_PFX = 2'd3;

  localparam logic [3:0] MAX_PFX = 4'(MAX_PREFIX_BYTES);

  logic [3:0] phase_r, phase_nxt;
  logic [3:0] pcnt_r, pcnt_nxt;
  logic [4:0] nbytes_r, nbytes_nxt;
  logic       osz_r, osz_nxt, asz_r, asz_nxt, rexw_r, rexw_nxt;
  logic [1:0] map_r, map_nxt, esc_r, esc_nxt;
  logic [2:0] disp_r, disp_nxt;
  logic [3:0] imm_r, imm_nxt;
  logic       tgp_r, tgp_nxt, sysc_r, sysc_nxt;

  logic                  ovalid_r;
  x86ild_pkg::out_item_t odata_r;

  logic       take;
  logic [1:0] go;
  logic [4:0] cnt;
  logic [7:0] b;
  logic [4:0] mm;
  logic       emit;
  logic [1:0] status;

  assign cls_ready = !ovalid_r || out_ready;
  assign take      = cls_valid && cls_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign b         = cls_data.code_byte;
  assign mm        = b[4:0];
  assign cnt       = (nbytes_r == 5'd31) ? nbytes_r : nbytes_r + 5'd1;

  function automatic logic [3:0] imm_size(input logic [3:0] c, input logic w,
                                         input logic o, input logic a);
    logic [3:0] s;
    s = 4'd0;
    case (c)
      x86ild_pkg::IM_B, x86ild_pkg::IM_TB: s = 4'd1;
      x86ild_pkg::IM_W: s = 4'd2;
      x86ild_pkg::IM_3: s = 4'd3;
      x86ild_pkg::IM_Z, x86ild_pkg::IM_TZ: s = (!w && o) ? 4'd2 : 4'd4;
      x86ild_pkg::IM_V: s = w ? 4'd8 : (o ? 4'd2 : 4'd4);
      x86ild_pkg::IM_M: s = a ? 4'd4 : 4'd8;
      x86ild_pkg::IM_REL4: s = 4'd4;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  always_comb begin
    x86ild_pkg::op_class_t c;
    logic                  do_start;
    logic                  do_modrm;
    logic                  do_after;
    logic [2:0]            d;
    phase_nxt = phase_r;  pcnt_nxt = pcnt_r;  nbytes_nxt = cnt;
    osz_nxt = osz_r;  asz_nxt = asz_r;  rexw_nxt = rexw_r;
    map_nxt = map_r;  esc_nxt = esc_r;  disp_nxt = disp_r;
    imm_nxt = imm_r;  tgp_nxt = tgp_r;  sysc_nxt = sysc_r;
    go = GO_ON;
    c = x86ild_pkg::mk(1'b1, 1'b0, x86ild_pkg::IM_NONE);
    do_start = 1'b0;
    do_modrm = 1'b0;
    do_after = 1'b0;
    d = 3'd0;
    unique case (phase_r)
      PH_PREFIX: begin
        if (cls_data.legacy_pfx || cls_data.rex) begin
          if (cls_data.is_66) osz_nxt = 1'b1;
          else if (cls_data.is_67) asz_nxt = 1'b1;
          else if (cls_data.rex) rexw_nxt = b[3];
          pcnt_nxt = pcnt_r + 4'd1;
          go = (pcnt_nxt >= MAX_PFX) ? GO_PFX : GO_ON;
        end else if (cls_data.is_c5) begin
          map_nxt = 2'd1; esc_nxt = 2'd1; phase_nxt = PH_ESC_REST;
        end else if (cls_data.is_c4) begin
          phase_nxt = PH_VEX3_MAP;
        end else if (cls_data.is_62) begin
          phase_nxt = PH_EVEX_MAP;
        end else if (cls_data.is_8f) begin
          phase_nxt = PH_XOP_MAP;
        end else if (cls_data.is_0f) begin
          sysc_nxt = pcnt_r == 4'd0;
          phase_nxt = PH_OP0F;
        end else begin
          map_nxt = 2'd0;
          c = cls_data.cls1;
          do_start = 1'b1;
        end
      end
      PH_VEX3_MAP: begin
        if (mm < 5'd1 || mm > 5'd3) go = GO_UNK;
        else begin
          map_nxt = mm[1:0]; esc_nxt = 2'd1; phase_nxt = PH_ESC_REST;
        end
      end
      PH_EVEX_MAP: begin
        if (b[1:0] == 2'd0) go = GO_UNK;
        else begin
          map_nxt = b[1:0]; esc_nxt = 2'd2; phase_nxt = PH_ESC_REST;
        end
      end
      PH_XOP_MAP: begin
        if (mm < 5'd8) begin
          // pop ev: this byte is the modrm
          map_nxt = 2'd0; imm_nxt = 4'd0; tgp_nxt = 1'b0;
          do_modrm = 1'b1;
        end else if (mm > 5'd10) begin
          go = GO_UNK;
        end else begin
          map_nxt = 2'(mm - 5'd7); esc_nxt = 2'd1; phase_nxt = PH_ESC_REST;
        end
      end
      PH_ESC_REST: begin
        if (esc_r != 2'd0) esc_nxt = esc_r - 2'd1;
        if (esc_nxt == 2'd0) phase_nxt = PH_VOPCODE;
      end
      PH_VOPCODE: begin
        do_start = 1'b1;
        unique case (map_r)
          2'd1: begin
            c = cls_data.cls0f;
            if (cls_data.code_byte[7:4] == 4'h8) c.imm = x86ild_pkg::IM_REL4;
          end
          2'd2: c = x86ild_pkg::mk(1'b0, 1'b1, x86ild_pkg::IM_NONE);
          2'd3: c = x86ild_pkg::mk(1'b0, 1'b1, x86ild_pkg::IM_B);
          default: c = x86ild_pkg::mk(1'b1, 1'b0, x86ild_pkg::IM_NONE);
        endcase
      end
      PH_OP0F: begin
        if (!cls_data.is_05) sysc_nxt = 1'b0;
        if (cls_data.is_38 || cls_data.is_3a) begin
          map_nxt = cls_data.is_38 ? 2'd2 : 2'd3;
          phase_nxt = PH_OP3;
        end else begin
          map_nxt = 2'd1;
          c = cls_data.cls0f;
          do_start = 1'b1;
        end
      end
      PH_OP3: begin
        do_start = 1'b1;
        c = (map_r == 2'd3) ? x86ild_pkg::mk(1'b0, 1'b1, x86ild_pkg::IM_B)
                            : x86ild_pkg::mk(1'b0, 1'b1, x86ild_pkg::IM_NONE);
      end
      PH_MODRM: do_modrm = 1'b1;
      PH_SIB: begin
        if (disp_r == 3'd0 && b[2:0] == 3'd5) disp_nxt = 3'd4;
        do_after = 1'b1;
      end
      PH_DISP: begin
        if (disp_r != 3'd0) disp_nxt = disp_r - 3'd1;
        do_after = 1'b1;
      end
      PH_IMM: begin
        if (imm_r != 4'd0) imm_nxt = imm_r - 4'd1;
        go = (imm_nxt != 4'd0) ? GO_ON : GO_OK;
      end
      default: go = GO_UNK;
    endcase

    if (do_start) begin
      if (c.unk) begin
        go = GO_UNK;
      end else if (c.imm == x86ild_pkg::IM_REL4) begin
        imm_nxt = 4'd4;
        do_after = 1'b1;
      end else begin
        imm_nxt = imm_size(c.imm, rexw_r, osz_r, asz_r);
        tgp_nxt = c.imm == x86ild_pkg::IM_TB || c.imm == x86ild_pkg::IM_TZ;
        disp_nxt = 3'd0;
        if (c.mrm) phase_nxt = PH_MODRM;
        else do_after = 1'b1;
      end
    end

    if (do_modrm) begin
      if (tgp_nxt && b[5:3] != 3'd0) imm_nxt = 4'd0;
      tgp_nxt = 1'b0;
      if (b[7:6] == 2'd1) d = 3'd1;
      else if (b[7:6] == 2'd2) d = 3'd4;
      else if (b[7:6] == 2'd0 && b[2:0] == 3'd5) d = 3'd4;
      else d = 3'd0;
      disp_nxt = d;
      if (b[7:6] != 2'd3 && b[2:0] == 3'd4) phase_nxt = PH_SIB;
      else do_after = 1'b1;
    end

    if (do_after) begin
      if (disp_nxt != 3'd0) phase_nxt = PH_DISP;
      else if (imm_nxt != 4'd0) phase_nxt = PH_IMM;
      else go = GO_OK;
    end

    emit = go != GO_ON || cls_data.region_end;
    unique case (go)
      GO_OK:   status = x86ild_pkg::ST_OK;
      GO_UNK:  status = x86ild_pkg::ST_UNKNOWN;
      GO_PFX:  status = x86ild_pkg::ST_PREFIX;
      default: status = x86ild_pkg::ST_TRUNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && emit)) begin
      phase_r <= PH_PREFIX; pcnt_r <= 4'd0; nbytes_r <= 5'd0;
      osz_r <= 1'b0; asz_r <= 1'b0; rexw_r <= 1'b0;
      map_r <= 2'd0; esc_r <= 2'd0; disp_r <= 3'd0;
      imm_r <= 4'd0; tgp_r <= 1'b0; sysc_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt; pcnt_r <= pcnt_nxt; nbytes_r <= nbytes_nxt;
      osz_r <= osz_nxt; asz_r <= asz_nxt; rexw_r <= rexw_nxt;
      map_r <= map_nxt; esc_r <= esc_nxt; disp_r <= disp_nxt;
      imm_r <= imm_nxt; tgp_r <= tgp_nxt; sysc_r <= sysc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cls_ready) begin
      ovalid_r <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      odata_r.instr_length  <= cnt;
      odata_r.decode_status <= status;
      odata_r.is_syscall    <= status == x86ild_pkg::ST_OK && sysc_nxt && cnt == 5'd2;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |=> (phase_r == PH_PREFIX && nbytes_r == 5'd0))
    else $error("decoder did not restart after a result");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_syscall |->
      (out_data.instr_length == 5'd2 && out_data.decode_status == x86ild_pkg::ST_OK))
    else $error("syscall flag on a result that is not a two-byte ok");
  assert property (@(posedge clk) disable iff (!rst_n) pcnt_r < MAX_PFX)
    else $error("prefix count passed its limit");
endmodule
`default_nettype wire

>>> src/x86_64_instruction_length_decoder_core.sv
// x86_64_instruction_length_decoder_core: top level of the length decoder
// depends on x86ild_pkg, x86ild_front, x86ild_fifo, x86ild_back
`default_nettype none
// Takes one byte of 64-bit x86 code per cycle and emits one result per instruction
// (length, status, syscall flag). Sustained rate is one byte per cycle while out_ready
// is high: the classifier stage, a two-entry queue and the length state machine each
// move one byte a cycle. The closing byte passes the classifier register and the queue
// before its result is registered. A result waiting in the output register holds the
// length state machine; the queue and the classifier register absorb up to three more
// bytes before in_ready drops. The decoder restarts on the byte after each result.
module x86_64_instruction_length_decoder_core #(
  parameter int MAX_PREFIX_BYTES = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire x86ild_pkg::in_item_t   in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output x86ild_pkg::out_item_t       out_data
);
  logic                  f_valid, f_ready, q_valid, q_ready;
  x86ild_pkg::cls_item_t f_data, q_data;

  x86ild_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  x86ild_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  x86ild_back #(.MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)) u_back (
    .clk, .rst_n,
    .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
